@@ rtl/tga_rle_pixel_decoder_unit_macros.svh @@
// Assertion macros shared by the pixel decoder checker.
// Needs a clock named clock and a synchronous active-high reset named reset.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define TGARLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tgarle assertion failed");

// next-cycle implication
`define TGARLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tgarle assertion failed");

`endif

@@ rtl/tgarle_pkg.sv @@
// Types and constants of the TGA RLE pixel decoder.
// No dependencies; used by every module of the block but the checker.
package tgarle_pkg;

   localparam logic [1:0] CSR_RLE_ENABLED     = 2'd0;
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd1;
   localparam logic [1:0] CSR_ALPHA_FOR_16BIT = 2'd2;

   localparam logic [2:0] BPP_MIN = 3'd2;
   localparam logic [2:0] BPP_MAX = 3'd4;
   localparam logic [2:0] BPP_RESET = 3'd3;

   localparam logic [6:0] HDR_COUNT_MASK = 7'h7f;
   localparam logic [7:0] FULL_ALPHA = 8'hff;

   typedef struct packed {
      logic       image_start;
      logic [7:0] data_byte;
   } in_item_type;

   typedef struct packed {
      logic [7:0] repeat_count;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic      valid;
      pixel_type pixel;
   } result_type;

   typedef struct packed {
      logic       rle_enabled;
      logic [2:0] bytes_per_pixel;
      logic       alpha_for_16bit;
   } cfg_type;

endpackage

@@ rtl/tgarle_in_stage.sv @@
// Input register of the pixel decoder: holds one accepted byte beat.
// Depends on tgarle_pkg.
module tgarle_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tgarle_pkg::in_item_type req_item,
   input  logic                   advance,
   output logic                   item_valid,
   output tgarle_pkg::in_item_type item
);

   logic                    valid_ff, valid_in;
   tgarle_pkg::in_item_type item_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/tgarle_decode.sv @@
// Packet and pixel decoder: config registers, stream state and pixel format.
// Depends on tgarle_pkg.
module tgarle_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [2:0]              csr_wdata,
   input  tgarle_pkg::in_item_type item,
   input  logic                    step,
   output tgarle_pkg::result_type  result
);

   tgarle_pkg::cfg_type cfg_ff;
   logic       expect_header_ff, expect_header_in;
   logic       run_mode_ff, run_mode_in;
   logic [7:0] packet_left_ff, packet_left_in;
   logic [1:0] byte_index_ff, byte_index_in;
   logic [3:0][7:0] pixel_bytes_ff, pixel_bytes_in;

   logic       eh, rm;
   logic [7:0] pl;
   logic [1:0] bi;
   logic [3:0][7:0] pb, pb_cur;
   logic [2:0] size;
   logic [2:0] bi_next;
   logic [15:0] v16;
   logic [7:0] pl_dec;

   always_comb begin
      if (cfg_ff.bytes_per_pixel < tgarle_pkg::BPP_MIN) begin
         size = tgarle_pkg::BPP_MIN;
      end else if (cfg_ff.bytes_per_pixel > tgarle_pkg::BPP_MAX) begin
         size = tgarle_pkg::BPP_MAX;
      end else begin
         size = cfg_ff.bytes_per_pixel;
      end
   end

   always_comb begin
      eh = item.image_start ? 1'b1 : expect_header_ff;
      rm = item.image_start ? 1'b0 : run_mode_ff;
      pl = item.image_start ? 8'd0 : packet_left_ff;
      bi = item.image_start ? 2'd0 : byte_index_ff;
      pb = item.image_start ? '0 : pixel_bytes_ff;
      pb_cur = pb;
      pb_cur[bi] = item.data_byte;
      bi_next = {1'b0, bi} + 3'd1;
      pl_dec = pl - 8'd1;
      v16 = {pb_cur[1], pb_cur[0]};

      expect_header_in = eh;
      run_mode_in      = rm;
      packet_left_in   = pl;
      byte_index_in    = bi;
      pixel_bytes_in   = pb_cur;
      result.valid     = 1'b0;

      if (size == tgarle_pkg::BPP_MIN) begin
         result.pixel.red   = {v16[14:10], 3'b000};
         result.pixel.green = {v16[9:5], 3'b000};
         result.pixel.blue  = {v16[4:0], 3'b000};
         if (cfg_ff.alpha_for_16bit) begin
            result.pixel.alpha = v16[15] ? tgarle_pkg::FULL_ALPHA : 8'd0;
         end else begin
            result.pixel.alpha = tgarle_pkg::FULL_ALPHA;
         end
      end else begin
         result.pixel.red   = pb_cur[2];
         result.pixel.green = pb_cur[1];
         result.pixel.blue  = pb_cur[0];
         result.pixel.alpha = (size == tgarle_pkg::BPP_MAX) ? pb_cur[3]
                                                            : tgarle_pkg::FULL_ALPHA;
      end
      result.pixel.repeat_count = 8'd1;

      if (cfg_ff.rle_enabled && eh) begin
         packet_left_in   = {1'b0, item.data_byte[6:0] & tgarle_pkg::HDR_COUNT_MASK} + 8'd1;
         run_mode_in      = item.data_byte[7];
         expect_header_in = 1'b0;
         byte_index_in    = 2'd0;
         pixel_bytes_in   = pb;
      end else if (bi_next < size) begin
         byte_index_in = bi_next[1:0];
      end else begin
         byte_index_in = 2'd0;
         result.valid  = 1'b1;
         if (cfg_ff.rle_enabled) begin
            if (rm) begin
               result.pixel.repeat_count = pl;
               packet_left_in   = 8'd0;
               expect_header_in = 1'b1;
            end else begin
               packet_left_in   = pl_dec;
               expect_header_in = (pl_dec == 8'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rle_enabled     <= 1'b0;
         cfg_ff.bytes_per_pixel <= tgarle_pkg::BPP_RESET;
         cfg_ff.alpha_for_16bit <= 1'b0;
         expect_header_ff <= 1'b1;
         run_mode_ff      <= 1'b0;
         packet_left_ff   <= 8'd0;
         byte_index_ff    <= 2'd0;
         pixel_bytes_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               tgarle_pkg::CSR_RLE_ENABLED: begin
                  cfg_ff.rle_enabled <= csr_wdata[0];
               end
               tgarle_pkg::CSR_BYTES_PER_PIXEL: begin
                  cfg_ff.bytes_per_pixel <= csr_wdata;
               end
               tgarle_pkg::CSR_ALPHA_FOR_16BIT: begin
                  cfg_ff.alpha_for_16bit <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (step) begin
            expect_header_ff <= expect_header_in;
            run_mode_ff      <= run_mode_in;
            packet_left_ff   <= packet_left_in;
            byte_index_ff    <= byte_index_in;
            pixel_bytes_ff   <= pixel_bytes_in;
         end
      end
   end

endmodule

@@ rtl/tgarle_out_stage.sv @@
// Result register of the pixel decoder: holds one pixel beat until taken.
// Depends on tgarle_pkg.
module tgarle_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tgarle_pkg::pixel_type pixel,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output tgarle_pkg::pixel_type rsp_pixel
);

   logic                  valid_ff, valid_in;
   tgarle_pkg::pixel_type pixel_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         pixel_ff <= pixel;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_pixel  = pixel_ff;

endmodule

@@ rtl/tga_rle_pixel_decoder_unit.sv @@
// TGA pixel-data decoder, top level: input register, decoder, result register.
// Depends on tgarle_pkg, tgarle_in_stage, tgarle_decode, tgarle_out_stage.
//
// Usage:
//   req channel takes one byte of the image pixel stream per beat; tuser marks
//   the first byte of an image and clears packet and pixel state first.
//   rsp channel gives one decoded pixel per beat with a repeat count; the
//   receiver replicates it repeat_count times. Header bytes and the leading
//   bytes of a pixel give no beat.
//   csr port writes rle_enabled, bytes_per_pixel and alpha_for_16bit; write
//   only while no byte is in flight.
// Timing:
//   A byte is accepted every cycle unless the result register is stalled. A
//   pixel beat passes through the input register and then the result register;
//   the packet state update is combinational logic between the two.
// Reset clears both registers and the stream state; a header is expected.
// When rsp_tready is low, the result holds; a further byte that completes a
// pixel waits in the input register and req_tready drops until room opens.
module tga_rle_pixel_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] image_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [39:32] repeat_count
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_wdata
);

   tgarle_pkg::in_item_type req_item, item;
   tgarle_pkg::result_type  result;
   tgarle_pkg::pixel_type   rsp_pixel;
   logic item_valid, advance, out_free, load;

   assign req_item.data_byte   = req_tdata;
   assign req_item.image_start = req_tuser;

   assign advance = item_valid && (out_free || !result.valid);
   assign load    = advance && result.valid;

   tgarle_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tgarle_decode u_dec (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item      (item),
      .step      (advance),
      .result    (result)
   );

   tgarle_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .pixel      (result.pixel),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_pixel  (rsp_pixel)
   );

   assign rsp_tdata = rsp_pixel;

endmodule

@@ rtl/tgarle_checker.sv @@
// Port-level checker for tga_rle_pixel_decoder_unit, bound to the top level.
// Depends on tga_rle_pixel_decoder_unit_macros.svh.
`include "tga_rle_pixel_decoder_unit_macros.svh"

module tgarle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_we,
   input logic [1:0]  csr_index,
   input logic [2:0]  csr_wdata
);

   `TGARLE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `TGARLE_ASSERT_NOW(a_repeat_nonzero, rsp_tvalid, rsp_tdata[39:32] != 8'd0)
   `TGARLE_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready)

endmodule

bind tga_rle_pixel_decoder_unit tgarle_checker u_tgarle_checker (.*);
